/* rtl/core/particle_sensor_duty_cycle_macros.svh */
// Assertion macros for the particle sensor duty-cycle block.
// Both sample on clk and are disabled while rst_n is low.
`ifndef PARTICLE_SENSOR_DUTY_CYCLE_MACROS_SVH
`define PARTICLE_SENSOR_DUTY_CYCLE_MACROS_SVH

`define PSDC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define PSDC_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

/* rtl/core/psdc_pkg.sv */
package psdc_pkg;

  localparam int WARMUP_SECONDS_DEF = 30;
  localparam int MS_PER_S           = 1000;
  localparam int MS_PER_MIN         = 60000;
  localparam int WAKE_FLOOR_ADD     = 5;
  localparam int WAKE_MIN_ADD       = 10;

  localparam int TIME_W     = 32;
  localparam int VAL_W      = 16;
  localparam int N_VALS     = 6;
  localparam int MIN_W      = 8;
  localparam int SEC_W      = 8;
  localparam int SLEEP_MS_W = 24;
  localparam int WAKE_MS_W  = 18;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 104;
  localparam int STAT_W     = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SENSOR_ENABLED = 3'd0,
    CFG_SLEEP_MINUTES  = 3'd1,
    CFG_WAKE_SECONDS   = 3'd2,
    CFG_EXTENDED_MODEL = 3'd3,
    CFG_PM25_LIMIT     = 3'd4
  } cfg_addr_t;

  typedef enum logic [1:0] {
    PH_ACTIVE = 2'd0,
    PH_WARMUP = 2'd1,
    PH_SLEEP  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_SLEEP = 2'd1,
    CMD_WAKE  = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NODATA   = 2'd1,
    ST_READERR  = 2'd2,
    ST_OTHERERR = 2'd3
  } status_t;

  localparam int PM1_IDX   = 0;
  localparam int PM25_IDX  = 1;
  localparam int PM10_IDX  = 2;
  localparam int HCHO_IDX  = 3;
  localparam int TEMP_IDX  = 4;
  localparam int HUMID_IDX = 5;

  typedef logic [VAL_W-1:0] val_arr_t [N_VALS];

  typedef struct packed {
    status_t              poll_status;
    phase_t               phase;
    logic                 power_pin;
    cmd_t                 sensor_command;
    logic                 values_updated;
    logic [VAL_W-1:0]     pm1_last;
    logic [VAL_W-1:0]     pm25_last;
    logic [VAL_W-1:0]     pm10_last;
    logic [VAL_W-1:0]     hcho_last;
    logic [VAL_W-1:0]     temp_last;
    logic [VAL_W-1:0]     humid_last;
  } result_t;

endpackage

/* rtl/core/particle_sensor_duty_cycle.sv */
// Particle sensor duty-cycle controller.
// Input channel (in_*): one word per sensor poll, carrying the poll time in
// milliseconds, the frame status in in_tuser and the six frame readings.
// Result channel (out_*): one word per poll with the poll status in out_tuser,
// the duty phase after the poll, the power-pin level, the command sent to the
// sensor, an update flag and the six held last readings.
// Configuration port (cfg_*): a write on every clock edge with cfg_we high;
// write only while no poll is in flight.
// An accepted poll's result is registered in the result or the skid register.
// Throughput: one poll per cycle while in_tready is high; the phase step is a
// subtract and compare against millisecond limits scaled on register writes.
// A result register and a skid register sit on the result side, so a poll is
// still taken while one result waits; in_tready drops only once both hold data.
// Reset (synchronous, rst_n low) sets active phase, start time zero, pin high,
// last readings zero and the register defaults; both result stages empty.
module particle_sensor_duty_cycle #(
  parameter int WARMUP_SECONDS = psdc_pkg::WARMUP_SECONDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // now_ms, pm1_in, pm25_in, pm10_in, hcho_in, temp_tenths_in, humid_tenths_in
  input  logic [psdc_pkg::IN_DATA_W-1:0]   in_tdata,
  // frame_status
  input  logic [psdc_pkg::STAT_W-1:0]      in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // phase, power_pin, sensor_command, values_updated, pm1_last, pm25_last,
  // pm10_last, hcho_last, temp_last, humid_last, zero pad
  output logic [psdc_pkg::OUT_DATA_W-1:0]  out_tdata,
  // poll_status
  output logic [psdc_pkg::STAT_W-1:0]      out_tuser,
  input  logic                             cfg_we,
  input  logic [psdc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [psdc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import psdc_pkg::*;

  `include "particle_sensor_duty_cycle_macros.svh"

  localparam int WAKE_FLOOR = WARMUP_SECONDS + WAKE_FLOOR_ADD;
  localparam int WAKE_MIN   = WARMUP_SECONDS + WAKE_MIN_ADD;
  localparam int WARMUP_MS  = WARMUP_SECONDS * MS_PER_S;

  logic                  enable_r;
  logic [MIN_W-1:0]      sleep_min_r;
  logic [SLEEP_MS_W-1:0] sleep_ms_r;
  logic [WAKE_MS_W-1:0]  wake_ms_r;
  logic                  ext_r;
  logic [VAL_W-1:0]      limit_r;

  phase_t                phase_r, phase_nxt;
  logic [TIME_W-1:0]     start_r, start_nxt;
  logic                  pin_r, pin_nxt;
  val_arr_t              vals_r, vals_nxt;

  result_t               main_r, skid_r, res_nxt;
  logic                  out_vld_r, skid_vld_r;

  logic [TIME_W-1:0]     now_ms;
  status_t               fstat;
  logic [VAL_W-1:0]      pm25_in;
  logic [TIME_W-1:0]     elapsed;
  logic [SEC_W-1:0]      wake_eff;
  logic                  push, pop;
  logic                  read_frame;
  status_t               status;
  cmd_t                  cmd;
  logic                  updated;

  assign now_ms  = in_tdata[31:0];
  assign pm25_in = in_tdata[63:48];
  assign fstat   = status_t'(in_tuser);

  assign in_tready  = !skid_vld_r;
  assign push       = in_tvalid && in_tready;
  assign pop        = out_vld_r && out_tready;
  assign out_tvalid = out_vld_r;

  assign wake_eff = (cfg_wdata[SEC_W-1:0] < SEC_W'(WAKE_FLOOR)) ?
                    SEC_W'(WAKE_MIN) : cfg_wdata[SEC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      sleep_min_r <= '0;
      sleep_ms_r  <= '0;
      wake_ms_r   <= WAKE_MS_W'(WAKE_MIN * MS_PER_S);
      ext_r       <= 1'b0;
      limit_r     <= VAL_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SENSOR_ENABLED: enable_r <= cfg_wdata[0];
        CFG_SLEEP_MINUTES: begin
          sleep_min_r <= cfg_wdata[MIN_W-1:0];
          sleep_ms_r  <= SLEEP_MS_W'(cfg_wdata[MIN_W-1:0]) * SLEEP_MS_W'(MS_PER_MIN);
        end
        CFG_WAKE_SECONDS:   wake_ms_r <= WAKE_MS_W'(wake_eff) * WAKE_MS_W'(MS_PER_S);
        CFG_EXTENDED_MODEL: ext_r     <= cfg_wdata[0];
        CFG_PM25_LIMIT:     limit_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign elapsed = now_ms - start_r;

  always_comb begin
    phase_nxt  = phase_r;
    start_nxt  = start_r;
    pin_nxt    = pin_r;
    vals_nxt   = vals_r;
    cmd        = CMD_NONE;
    status     = ST_NODATA;
    updated    = 1'b0;
    read_frame = 1'b0;
    if (enable_r) begin
      if (sleep_min_r == '0) begin
        read_frame = 1'b1;
        if (phase_r == PH_SLEEP) begin
          pin_nxt   = 1'b1;
          cmd       = CMD_WAKE;
          phase_nxt = PH_WARMUP;
          start_nxt = now_ms;
        end
      end else begin
        unique case (phase_r)
          PH_SLEEP: begin
            if (elapsed >= TIME_W'(sleep_ms_r)) begin
              pin_nxt   = 1'b1;
              cmd       = CMD_WAKE;
              phase_nxt = PH_WARMUP;
              start_nxt = now_ms;
            end
          end
          PH_WARMUP: begin
            if (elapsed >= TIME_W'(WARMUP_MS)) begin
              phase_nxt = PH_ACTIVE;
              start_nxt = now_ms;
            end
          end
          default: begin
            if (elapsed >= TIME_W'(wake_ms_r)) begin
              cmd       = CMD_SLEEP;
              pin_nxt   = 1'b0;
              phase_nxt = PH_SLEEP;
              start_nxt = now_ms;
            end else begin
              read_frame = 1'b1;
            end
          end
        endcase
      end
      if (read_frame) begin
        status = fstat;
        if (fstat == ST_OK) begin
          if (pm25_in > limit_r) begin
            status = ST_READERR;
          end else begin
            updated            = 1'b1;
            vals_nxt[PM1_IDX]  = in_tdata[47:32];
            vals_nxt[PM25_IDX] = pm25_in;
            vals_nxt[PM10_IDX] = in_tdata[79:64];
            if (ext_r) begin
              vals_nxt[HCHO_IDX]  = in_tdata[95:80];
              vals_nxt[TEMP_IDX]  = in_tdata[111:96];
              vals_nxt[HUMID_IDX] = in_tdata[127:112];
            end
          end
        end
      end
    end
    res_nxt.poll_status    = status;
    res_nxt.phase          = phase_nxt;
    res_nxt.power_pin      = pin_nxt;
    res_nxt.sensor_command = cmd;
    res_nxt.values_updated = updated;
    res_nxt.pm1_last       = vals_nxt[PM1_IDX];
    res_nxt.pm25_last      = vals_nxt[PM25_IDX];
    res_nxt.pm10_last      = vals_nxt[PM10_IDX];
    res_nxt.hcho_last      = vals_nxt[HCHO_IDX];
    res_nxt.temp_last      = vals_nxt[TEMP_IDX];
    res_nxt.humid_last     = vals_nxt[HUMID_IDX];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ACTIVE;
      start_r <= '0;
      pin_r   <= 1'b1;
      for (int i = 0; i < N_VALS; i++) begin
        vals_r[i] <= '0;
      end
    end else if (cfg_we && cfg_addr == CFG_SENSOR_ENABLED) begin
      pin_r <= cfg_wdata[0];
    end else if (push) begin
      phase_r <= phase_nxt;
      start_r <= start_nxt;
      pin_r   <= pin_nxt;
      vals_r  <= vals_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (pop) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else if (!push) begin
        out_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_vld_r) begin
        main_r <= skid_r;
      end else if (push) begin
        main_r <= res_nxt;
      end
    end else if (push) begin
      if (!out_vld_r) begin
        main_r <= res_nxt;
      end else begin
        skid_r <= res_nxt;
      end
    end
  end

  assign out_tuser = main_r.poll_status;
  assign out_tdata = {2'b00,
                      main_r.humid_last, main_r.temp_last, main_r.hcho_last,
                      main_r.pm10_last, main_r.pm25_last, main_r.pm1_last,
                      main_r.values_updated, main_r.sensor_command,
                      main_r.power_pin, main_r.phase};

  `PSDC_ASSERT_NEVER(a_skid_without_main, skid_vld_r && !out_vld_r, "skid holds word over empty output")
  `PSDC_ASSERT_IMPL(a_pin_low_only_asleep, !pin_r, phase_r == PH_SLEEP || !enable_r, "pin low while awake and enabled")
  `PSDC_ASSERT_IMPL(a_update_means_ok, out_vld_r && main_r.values_updated, main_r.poll_status == ST_OK, "update with non-ok status")
  `PSDC_ASSERT_IMPL(a_wake_enters_warmup, out_vld_r && main_r.sensor_command == CMD_WAKE, main_r.phase == PH_WARMUP && main_r.power_pin, "wake without warmup")

endmodule
